/* rtl/core/vmmio_pkg.sv */
// Shared constants, codes and types of the virtio-mmio transport register file.
package vmmio_pkg;

	localparam int QUEUE_COUNT_DEF = 8;
	localparam int QUEUE_MAX_LEN   = 256;

	localparam logic [31:0] MAGIC_WORD      = 32'h7472_6976;
	localparam logic [31:0] VERSION_WORD    = 32'd2;
	localparam logic [31:0] USED_BUFFER_BIT = 32'd1;
	localparam logic [3:0]  ACCESS_WORD     = 4'd4;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_USED  = 2'd2;

	localparam logic [1:0] CFG_DEVICE_ID = 2'd0;
	localparam logic [1:0] CFG_VENDOR_ID = 2'd1;
	localparam logic [1:0] CFG_FEATURES  = 2'd2;

	localparam logic [7:0] OFF_MAGIC        = 8'h00;
	localparam logic [7:0] OFF_VERSION      = 8'h04;
	localparam logic [7:0] OFF_DEVICE_ID    = 8'h08;
	localparam logic [7:0] OFF_VENDOR_ID    = 8'h0C;
	localparam logic [7:0] OFF_DEV_FEAT     = 8'h10;
	localparam logic [7:0] OFF_DEV_FEAT_SEL = 8'h14;
	localparam logic [7:0] OFF_DRV_FEAT     = 8'h20;
	localparam logic [7:0] OFF_DRV_FEAT_SEL = 8'h24;
	localparam logic [7:0] OFF_QUEUE_SEL    = 8'h30;
	localparam logic [7:0] OFF_QUEUE_MAX    = 8'h34;
	localparam logic [7:0] OFF_QUEUE_LEN    = 8'h38;
	localparam logic [7:0] OFF_QUEUE_READY  = 8'h44;
	localparam logic [7:0] OFF_QUEUE_NOTIFY = 8'h50;
	localparam logic [7:0] OFF_IRQ_STATUS   = 8'h60;
	localparam logic [7:0] OFF_IRQ_ACK      = 8'h64;
	localparam logic [7:0] OFF_STATUS       = 8'h70;
	localparam logic [7:0] OFF_DESC_LO      = 8'h80;
	localparam logic [7:0] OFF_DESC_HI      = 8'h84;
	localparam logic [7:0] OFF_AVAIL_LO     = 8'h90;
	localparam logic [7:0] OFF_AVAIL_HI     = 8'h94;
	localparam logic [7:0] OFF_USED_LO      = 8'hA0;
	localparam logic [7:0] OFF_USED_HI      = 8'hA4;
	localparam logic [7:0] OFF_CONFIG_GEN   = 8'hFC;

	typedef enum logic [1:0] {
		RING_DESC,
		RING_AVAIL,
		RING_USED
	} ring_t;

	typedef struct packed {
		logic  len_we;
		logic  rdy_we;
		logic  ring_we;
		logic  ring_hi;
		ring_t ring_sel;
	} qwr_t;

	typedef struct packed {
		logic [15:0] len;
		logic        en;
		logic [63:0] desc;
		logic [63:0] avail;
		logic [63:0] used;
	} qrd_t;

endpackage

/* rtl/core/vmmio_qregs.sv */
// Per-queue length, ready bit and ring address registers.
module vmmio_qregs #(
	parameter int QUEUE_COUNT = vmmio_pkg::QUEUE_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clr,
	input  vmmio_pkg::qwr_t        wr,
	input  logic [$clog2((QUEUE_COUNT > 1) ? QUEUE_COUNT : 2)-1:0] idx,
	input  logic [31:0]            wdata,
	output vmmio_pkg::qrd_t        rd
);

	logic [15:0] len_q   [QUEUE_COUNT];
	logic        en_q    [QUEUE_COUNT];
	logic [63:0] desc_q  [QUEUE_COUNT];
	logic [63:0] avail_q [QUEUE_COUNT];
	logic [63:0] used_q  [QUEUE_COUNT];
	logic [63:0] ring_cur;
	logic [63:0] ring_new;

	always_comb begin
		rd.len   = len_q[idx];
		rd.en    = en_q[idx];
		rd.desc  = desc_q[idx];
		rd.avail = avail_q[idx];
		rd.used  = used_q[idx];
	end

	always_comb begin
		case (wr.ring_sel)
			vmmio_pkg::RING_DESC: begin
				ring_cur = desc_q[idx];
			end
			vmmio_pkg::RING_AVAIL: begin
				ring_cur = avail_q[idx];
			end
			vmmio_pkg::RING_USED: begin
				ring_cur = used_q[idx];
			end
			default: begin
				ring_cur = '0;
			end
		endcase
		if (wr.ring_hi) begin
			ring_new = {wdata, ring_cur[31:0]};
		end else begin
			ring_new = {ring_cur[63:32], wdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				len_q[i]   <= '0;
				en_q[i]    <= 1'b0;
				desc_q[i]  <= '0;
				avail_q[i] <= '0;
				used_q[i]  <= '0;
			end
		end else if (clr) begin
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				len_q[i]   <= '0;
				en_q[i]    <= 1'b0;
				desc_q[i]  <= '0;
				avail_q[i] <= '0;
				used_q[i]  <= '0;
			end
		end else begin
			if (wr.len_we) begin
				len_q[idx] <= wdata[15:0];
			end
			if (wr.rdy_we) begin
				en_q[idx] <= |wdata;
			end
			if (wr.ring_we) begin
				case (wr.ring_sel)
					vmmio_pkg::RING_DESC: begin
						desc_q[idx] <= ring_new;
					end
					vmmio_pkg::RING_AVAIL: begin
						avail_q[idx] <= ring_new;
					end
					vmmio_pkg::RING_USED: begin
						used_q[idx] <= ring_new;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

/* rtl/core/virtio_mmio_transport_registers_top.sv */
// Top level of the virtio-mmio transport register file.
//
//  channel  direction  handshake                payload
//  in       request    in_valid / in_stall      kind, offset, access_size, write_data
//  out      result     out_valid / out_stall    read_data, access_error, irq_level,
//                                               notify_valid, notify_qid, device_reset
//  cfg      write      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One request per cycle while in_stall is low.
// Requests land in an input stage, then decode and register update fill the result register.
// Reset clears all transport state and the identity registers; no clearing pass.
// A stalled result holds; the input stage takes one more request if it is empty, then stalls the input.
// cfg_ready is always high.
module virtio_mmio_transport_registers_top #(
	parameter int QUEUE_COUNT = vmmio_pkg::QUEUE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  offset,
	input  logic [3:0]  access_size,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        access_error,
	output logic        irq_level,
	output logic        notify_valid,
	output logic [2:0]  notify_qid,
	output logic        device_reset,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  offset_s1;
	logic [3:0]  size_s1;
	logic [31:0] data_s1;

	logic [31:0] device_id_q;
	logic [31:0] vendor_id_q;
	logic [63:0] offered_q;

	logic [31:0] dev_sel_q, dev_sel_d;
	logic [31:0] drv_sel_q, drv_sel_d;
	logic [63:0] acc_q, acc_d;
	logic [31:0] qsel_q, qsel_d;
	logic [31:0] irq_q, irq_d;
	logic [7:0]  status_q, status_d;

	logic        out_valid_q;
	logic [31:0] read_data_q;
	logic        err_q;
	logic        irq_level_q;
	logic        notify_valid_q;
	logic [2:0]  notify_qid_q;
	logic        device_reset_q;

	logic        advance;
	logic        proc;
	logic        size_ok;
	logic        qok;
	logic [QW-1:0] q_idx;
	logic [31:0] rd_d;
	logic        err_d;
	logic        nv_d;
	logic [2:0]  nq_d;
	logic        drst_d;
	logic        qclr;
	vmmio_pkg::qwr_t qwr;
	vmmio_pkg::qrd_t qrd;

	assign advance   = !out_valid_q || !out_stall;
	assign proc      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign size_ok   = (size_s1 == vmmio_pkg::ACCESS_WORD);
	assign qok       = (qsel_q < 32'(QUEUE_COUNT));
	assign q_idx     = qok ? qsel_q[QW-1:0] : '0;

	vmmio_qregs #(
		.QUEUE_COUNT(QUEUE_COUNT)
	) u_qregs (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (qclr),
		.wr     (qwr),
		.idx    (q_idx),
		.wdata  (data_s1),
		.rd     (qrd)
	);

	// hold the request until the result register can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1   <= kind;
			offset_s1 <= offset;
			size_s1   <= access_size;
			data_s1   <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= '0;
			vendor_id_q <= '0;
			offered_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vmmio_pkg::CFG_DEVICE_ID: begin
					device_id_q <= cfg_data[31:0];
				end
				vmmio_pkg::CFG_VENDOR_ID: begin
					vendor_id_q <= cfg_data[31:0];
				end
				vmmio_pkg::CFG_FEATURES: begin
					offered_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		rd_d      = '0;
		err_d     = 1'b0;
		nv_d      = 1'b0;
		nq_d      = '0;
		drst_d    = 1'b0;
		qclr      = 1'b0;
		qwr       = '0;
		dev_sel_d = dev_sel_q;
		drv_sel_d = drv_sel_q;
		acc_d     = acc_q;
		qsel_d    = qsel_q;
		irq_d     = irq_q;
		status_d  = status_q;
		if (proc) begin
			case (kind_s1)
				vmmio_pkg::KIND_READ: begin
					if (!size_ok) begin
						err_d = 1'b1;
					end else begin
						case (offset_s1)
							vmmio_pkg::OFF_MAGIC: begin
								rd_d = vmmio_pkg::MAGIC_WORD;
							end
							vmmio_pkg::OFF_VERSION: begin
								rd_d = vmmio_pkg::VERSION_WORD;
							end
							vmmio_pkg::OFF_DEVICE_ID: begin
								rd_d = device_id_q;
							end
							vmmio_pkg::OFF_VENDOR_ID: begin
								rd_d = vendor_id_q;
							end
							vmmio_pkg::OFF_DEV_FEAT: begin
								if (dev_sel_q == 32'd0) begin
									rd_d = offered_q[31:0];
								end else if (dev_sel_q == 32'd1) begin
									rd_d = offered_q[63:32];
								end
							end
							vmmio_pkg::OFF_DEV_FEAT_SEL: begin
								rd_d = dev_sel_q;
							end
							vmmio_pkg::OFF_DRV_FEAT: begin
								rd_d = drv_sel_q[0] ? acc_q[63:32] : acc_q[31:0];
							end
							vmmio_pkg::OFF_DRV_FEAT_SEL: begin
								rd_d = drv_sel_q;
							end
							vmmio_pkg::OFF_QUEUE_SEL: begin
								rd_d = qsel_q;
							end
							vmmio_pkg::OFF_QUEUE_MAX: begin
								rd_d = qok ? 32'(vmmio_pkg::QUEUE_MAX_LEN) : '0;
							end
							vmmio_pkg::OFF_QUEUE_LEN: begin
								rd_d = qok ? {16'd0, qrd.len} : '0;
							end
							vmmio_pkg::OFF_QUEUE_READY: begin
								rd_d = qok ? {31'd0, qrd.en} : '0;
							end
							vmmio_pkg::OFF_IRQ_STATUS: begin
								rd_d = irq_q;
							end
							vmmio_pkg::OFF_STATUS: begin
								rd_d = {24'd0, status_q};
							end
							vmmio_pkg::OFF_DESC_LO: begin
								rd_d = qok ? qrd.desc[31:0] : '0;
							end
							vmmio_pkg::OFF_DESC_HI: begin
								rd_d = qok ? qrd.desc[63:32] : '0;
							end
							vmmio_pkg::OFF_AVAIL_LO: begin
								rd_d = qok ? qrd.avail[31:0] : '0;
							end
							vmmio_pkg::OFF_AVAIL_HI: begin
								rd_d = qok ? qrd.avail[63:32] : '0;
							end
							vmmio_pkg::OFF_USED_LO: begin
								rd_d = qok ? qrd.used[31:0] : '0;
							end
							vmmio_pkg::OFF_USED_HI: begin
								rd_d = qok ? qrd.used[63:32] : '0;
							end
							vmmio_pkg::OFF_CONFIG_GEN: begin
								rd_d = '0;
							end
							default: begin
								err_d = 1'b1;
							end
						endcase
					end
				end
				vmmio_pkg::KIND_WRITE: begin
					if (!size_ok) begin
						err_d = 1'b1;
					end else begin
						case (offset_s1)
							vmmio_pkg::OFF_DEV_FEAT_SEL: begin
								dev_sel_d = data_s1;
							end
							vmmio_pkg::OFF_DRV_FEAT: begin
								if (drv_sel_q[0]) begin
									acc_d = {data_s1, acc_q[31:0]};
								end else begin
									acc_d = {acc_q[63:32], data_s1};
								end
							end
							vmmio_pkg::OFF_DRV_FEAT_SEL: begin
								drv_sel_d = data_s1;
							end
							vmmio_pkg::OFF_QUEUE_SEL: begin
								qsel_d = data_s1;
							end
							vmmio_pkg::OFF_QUEUE_LEN: begin
								qwr.len_we = qok;
							end
							vmmio_pkg::OFF_QUEUE_READY: begin
								qwr.rdy_we = qok;
							end
							vmmio_pkg::OFF_QUEUE_NOTIFY: begin
								if (data_s1 < 32'(QUEUE_COUNT)) begin
									nv_d = 1'b1;
									nq_d = data_s1[2:0];
								end
							end
							vmmio_pkg::OFF_IRQ_ACK: begin
								irq_d = irq_q & ~data_s1;
							end
							vmmio_pkg::OFF_STATUS: begin
								status_d = data_s1[7:0];
								if (data_s1[7:0] == 8'd0) begin
									dev_sel_d = '0;
									drv_sel_d = '0;
									acc_d     = '0;
									qsel_d    = '0;
									irq_d     = '0;
									qclr      = 1'b1;
									drst_d    = 1'b1;
								end
							end
							vmmio_pkg::OFF_DESC_LO: begin
								qwr.ring_we  = qok;
								qwr.ring_sel = vmmio_pkg::RING_DESC;
							end
							vmmio_pkg::OFF_DESC_HI: begin
								qwr.ring_we  = qok;
								qwr.ring_hi  = 1'b1;
								qwr.ring_sel = vmmio_pkg::RING_DESC;
							end
							vmmio_pkg::OFF_AVAIL_LO: begin
								qwr.ring_we  = qok;
								qwr.ring_sel = vmmio_pkg::RING_AVAIL;
							end
							vmmio_pkg::OFF_AVAIL_HI: begin
								qwr.ring_we  = qok;
								qwr.ring_hi  = 1'b1;
								qwr.ring_sel = vmmio_pkg::RING_AVAIL;
							end
							vmmio_pkg::OFF_USED_LO: begin
								qwr.ring_we  = qok;
								qwr.ring_sel = vmmio_pkg::RING_USED;
							end
							vmmio_pkg::OFF_USED_HI: begin
								qwr.ring_we  = qok;
								qwr.ring_hi  = 1'b1;
								qwr.ring_sel = vmmio_pkg::RING_USED;
							end
							default: begin
								err_d = 1'b1;
							end
						endcase
					end
				end
				vmmio_pkg::KIND_USED: begin
					irq_d = irq_q | vmmio_pkg::USED_BUFFER_BIT;
				end
				default: begin
				end
			endcase
		end
	end

	// advance transport state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_sel_q <= '0;
			drv_sel_q <= '0;
			acc_q     <= '0;
			qsel_q    <= '0;
			irq_q     <= '0;
			status_q  <= '0;
		end else if (proc) begin
			dev_sel_q <= dev_sel_d;
			drv_sel_q <= drv_sel_d;
			acc_q     <= acc_d;
			qsel_q    <= qsel_d;
			irq_q     <= irq_d;
			status_q  <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			read_data_q    <= rd_d;
			err_q          <= err_d;
			irq_level_q    <= |irq_d;
			notify_valid_q <= nv_d;
			notify_qid_q   <= nq_d;
			device_reset_q <= drst_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign access_error = err_q;
	assign irq_level    = irq_level_q;
	assign notify_valid = notify_valid_q;
	assign notify_qid   = notify_qid_q;
	assign device_reset = device_reset_q;

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && access_error |-> read_data == '0 && !notify_valid && !device_reset)
		else $error("error result carries data or side effects");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && device_reset |-> !irq_level && !notify_valid)
		else $error("transport reset result shows interrupt or notify");

	a_notify_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !notify_valid |-> notify_qid == '0)
		else $error("queue index without notify");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(data_s1) && $stable(offset_s1))
		else $error("input stage lost a held request");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the virtio-mmio transport register file top level.
`timescale 1ns / 1ps

module tb_top;

	localparam int          NQ           = vmmio_pkg::QUEUE_COUNT_DEF;
	localparam logic [1:0]  KIND_UNUSED  = 2'd3;
	localparam int          PLAN_LEN     = 27;
	localparam int          PHASE_ITEMS  = 185;
	localparam int          CALM_ITEMS   = 120;
	localparam int          HOLD_AT      = 200;
	localparam int          HOLD_CYCLES  = 150;
	localparam int          SETTLE       = 4;

	typedef struct packed {
		logic [31:0] rdata;
		logic        err;
		logic        irq;
		logic        nv;
		logic [2:0]  nq;
		logic        rst;
	} access_result_t;

	typedef struct packed {
		logic [1:0]  k;
		logic [7:0]  off;
		logic [3:0]  sz;
		logic [31:0] d;
		logic        known;
		logic [31:0] rd;
		logic        err;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [7:0]  offset;
	logic [3:0]  access_size;
	logic [31:0] write_data;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] read_data;
	logic        access_error;
	logic        irq_level;
	logic        notify_valid;
	logic [2:0]  notify_qid;
	logic        device_reset;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	// model of the register file
	logic [31:0] id_reg, vendor_reg;
	logic [63:0] feat_offer;
	logic [31:0] dev_sel, drv_sel, q_sel, irq_stat;
	logic [63:0] drv_feat;
	logic [7:0]  status_b;
	logic [15:0] q_len [NQ];
	logic        q_rdy [NQ];
	logic [63:0] q_ring [3][NQ];

	access_result_t pending_results[$];
	plan_row_t      bringup_plan [PLAN_LEN];
	logic [7:0]     reg_map [23];

	int  n_accepted = 0;
	int  n_results  = 0;
	int  n_notify   = 0;
	int  n_resets   = 0;
	int  n_errors   = 0;
	int  n_fail     = 0;
	int  n_settings = 0;
	bit  calm       = 1'b0;

	virtio_mmio_transport_registers_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.offset       (offset),
		.access_size  (access_size),
		.write_data   (write_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.access_error (access_error),
		.irq_level    (irq_level),
		.notify_valid (notify_valid),
		.notify_qid   (notify_qid),
		.device_reset (device_reset),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic void wipe_transport();
		dev_sel  = '0;
		drv_sel  = '0;
		drv_feat = '0;
		q_sel    = '0;
		irq_stat = '0;
		for (int i = 0; i < NQ; i++) begin
			q_len[i] = '0;
			q_rdy[i] = 1'b0;
			for (int r = 0; r < 3; r++)
				q_ring[r][i] = '0;
		end
	endfunction

	function automatic access_result_t predict_access(input logic [1:0] k, input logic [7:0] off,
			input logic [3:0] sz, input logic [31:0] d);
		access_result_t   res;
		logic             qok, hit;
		logic [2:0]       q;
		vmmio_pkg::ring_t which;
		res   = '0;
		qok   = q_sel < NQ;
		q     = qok ? q_sel[2:0] : 3'd0;
		which = vmmio_pkg::ring_t'(off[5:4]);
		hit   = 1'b1;
		if (k == vmmio_pkg::KIND_READ && sz == vmmio_pkg::ACCESS_WORD) begin
			case (off)
				vmmio_pkg::OFF_MAGIC:        res.rdata = vmmio_pkg::MAGIC_WORD;
				vmmio_pkg::OFF_VERSION:      res.rdata = vmmio_pkg::VERSION_WORD;
				vmmio_pkg::OFF_DEVICE_ID:    res.rdata = id_reg;
				vmmio_pkg::OFF_VENDOR_ID:    res.rdata = vendor_reg;
				vmmio_pkg::OFF_DEV_FEAT:     res.rdata = (dev_sel == 0) ? feat_offer[31:0] :
					(dev_sel == 1) ? feat_offer[63:32] : 32'd0;
				vmmio_pkg::OFF_DEV_FEAT_SEL: res.rdata = dev_sel;
				vmmio_pkg::OFF_DRV_FEAT:
					res.rdata = drv_sel[0] ? drv_feat[63:32] : drv_feat[31:0];
				vmmio_pkg::OFF_DRV_FEAT_SEL: res.rdata = drv_sel;
				vmmio_pkg::OFF_QUEUE_SEL:    res.rdata = q_sel;
				vmmio_pkg::OFF_QUEUE_MAX:
					res.rdata = qok ? 32'(vmmio_pkg::QUEUE_MAX_LEN) : 32'd0;
				vmmio_pkg::OFF_QUEUE_LEN:    res.rdata = qok ? {16'd0, q_len[q]} : 32'd0;
				vmmio_pkg::OFF_QUEUE_READY:  res.rdata = qok ? {31'd0, q_rdy[q]} : 32'd0;
				vmmio_pkg::OFF_IRQ_STATUS:   res.rdata = irq_stat;
				vmmio_pkg::OFF_STATUS:       res.rdata = {24'd0, status_b};
				vmmio_pkg::OFF_DESC_LO, vmmio_pkg::OFF_AVAIL_LO, vmmio_pkg::OFF_USED_LO,
				vmmio_pkg::OFF_DESC_HI, vmmio_pkg::OFF_AVAIL_HI, vmmio_pkg::OFF_USED_HI: begin
					if (qok)
						res.rdata = off[2] ? q_ring[which][q][63:32] : q_ring[which][q][31:0];
				end
				vmmio_pkg::OFF_CONFIG_GEN:   res.rdata = 32'd0;
				default:                     hit = 1'b0;
			endcase
		end else if (k == vmmio_pkg::KIND_WRITE && sz == vmmio_pkg::ACCESS_WORD) begin
			case (off)
				vmmio_pkg::OFF_DEV_FEAT_SEL: dev_sel = d;
				vmmio_pkg::OFF_DRV_FEAT: begin
					if (drv_sel[0])
						drv_feat[63:32] = d;
					else
						drv_feat[31:0] = d;
				end
				vmmio_pkg::OFF_DRV_FEAT_SEL: drv_sel = d;
				vmmio_pkg::OFF_QUEUE_SEL:    q_sel = d;
				vmmio_pkg::OFF_QUEUE_LEN:    if (qok) q_len[q] = d[15:0];
				vmmio_pkg::OFF_QUEUE_READY:  if (qok) q_rdy[q] = (d != 0);
				vmmio_pkg::OFF_QUEUE_NOTIFY: begin
					if (d < NQ) begin
						res.nv = 1'b1;
						res.nq = d[2:0];
					end
				end
				vmmio_pkg::OFF_IRQ_ACK:      irq_stat = irq_stat & ~d;
				vmmio_pkg::OFF_STATUS: begin
					status_b = d[7:0];
					if (status_b == 0) begin
						wipe_transport();
						res.rst = 1'b1;
					end
				end
				vmmio_pkg::OFF_DESC_LO, vmmio_pkg::OFF_AVAIL_LO, vmmio_pkg::OFF_USED_LO,
				vmmio_pkg::OFF_DESC_HI, vmmio_pkg::OFF_AVAIL_HI, vmmio_pkg::OFF_USED_HI: begin
					if (qok) begin
						if (off[2])
							q_ring[which][q][63:32] = d;
						else
							q_ring[which][q][31:0] = d;
					end
				end
				default:                     hit = 1'b0;
			endcase
		end else if (k == vmmio_pkg::KIND_USED) begin
			irq_stat = irq_stat | vmmio_pkg::USED_BUFFER_BIT;
		end else if (k != KIND_UNUSED) begin
			hit = 1'b0;
		end
		if (!hit) begin
			res.rdata = '0;
			res.err   = 1'b1;
		end
		res.irq = (irq_stat != 0);
		return res;
	endfunction

	task automatic send_request(input logic [1:0] k, input logic [7:0] off, input logic [3:0] sz,
			input logic [31:0] d, input logic known, input logic [31:0] krd, input logic kerr);
		access_result_t res;
		@(negedge clk);
		in_valid    = 1'b1;
		kind        = k;
		offset      = off;
		access_size = sz;
		write_data  = d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		res = predict_access(k, off, sz, d);
		if (known) begin
			res.rdata = krd;
			res.err   = kerr;
		end
		pending_results.push_back(res);
		n_accepted++;
	endtask

	task automatic sender_gap();
		int n;
		if (!calm && $urandom_range(7) == 0) begin
			n = $urandom_range(19, 1);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_identity(input logic [31:0] id, input logic [31:0] vendor,
			input logic [63:0] feat);
		logic [63:0] vals [3];
		vals = '{{32'd0, id}, {32'd0, vendor}, feat};
		for (int i = 0; i < 3; i++) begin
			@(negedge clk);
			cfg_valid = 1'b1;
			cfg_index = 2'(i);
			cfg_data  = vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (2'(i))
				vmmio_pkg::CFG_DEVICE_ID: id_reg     = vals[i][31:0];
				vmmio_pkg::CFG_VENDOR_ID: vendor_reg = vals[i][31:0];
				vmmio_pkg::CFG_FEATURES:  feat_offer = vals[i];
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_valid = 1'b0;
		n_settings++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk) begin : result_checker
		access_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				n_fail++;
			end else begin
				want = pending_results.pop_front();
				check_field("read_data", want.rdata, read_data);
				check_field("access_error", want.err, access_error);
				check_field("irq_level", want.irq, irq_level);
				check_field("notify_valid", want.nv, notify_valid);
				check_field("notify_qid", want.nq, notify_qid);
				check_field("device_reset", want.rst, device_reset);
				n_results++;
				n_notify += want.nv;
				n_resets += want.rst;
				n_errors += want.err;
			end
		end
	end

	initial begin : result_backpressure
		int stall_left;
		bit held_off;
		stall_left = 0;
		held_off   = 1'b0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && !held_off && n_accepted >= HOLD_AT) begin
				held_off   = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm && $urandom_range(9) == 0) begin
				stall_left = $urandom_range(19, 1);
			end
			out_stall = (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin
		#2_000_000;
		$display("** virtio_mmio_transport_registers_top: FAILED **");
		$finish;
	end

	initial begin : stimulus
		logic [1:0]  k;
		logic [7:0]  off;
		logic [3:0]  sz;
		logic [31:0] d;
		int          r;
		logic [63:0] feat_pick;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		kind        = '0;
		offset      = '0;
		access_size = '0;
		write_data  = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		id_reg      = '0;
		vendor_reg  = '0;
		feat_offer  = '0;
		status_b    = '0;
		wipe_transport();
		reg_map = '{vmmio_pkg::OFF_MAGIC, vmmio_pkg::OFF_VERSION, vmmio_pkg::OFF_DEVICE_ID,
			vmmio_pkg::OFF_VENDOR_ID, vmmio_pkg::OFF_DEV_FEAT, vmmio_pkg::OFF_DEV_FEAT_SEL,
			vmmio_pkg::OFF_DRV_FEAT, vmmio_pkg::OFF_DRV_FEAT_SEL, vmmio_pkg::OFF_QUEUE_SEL,
			vmmio_pkg::OFF_QUEUE_MAX, vmmio_pkg::OFF_QUEUE_LEN, vmmio_pkg::OFF_QUEUE_READY,
			vmmio_pkg::OFF_QUEUE_NOTIFY, vmmio_pkg::OFF_IRQ_STATUS, vmmio_pkg::OFF_IRQ_ACK,
			vmmio_pkg::OFF_STATUS, vmmio_pkg::OFF_DESC_LO, vmmio_pkg::OFF_DESC_HI,
			vmmio_pkg::OFF_AVAIL_LO, vmmio_pkg::OFF_AVAIL_HI, vmmio_pkg::OFF_USED_LO,
			vmmio_pkg::OFF_USED_HI, vmmio_pkg::OFF_CONFIG_GEN};
		bringup_plan = '{
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_MAGIC, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b1, vmmio_pkg::MAGIC_WORD, 1'b0},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_VERSION, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b1, vmmio_pkg::VERSION_WORD, 1'b0},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_DEVICE_ID, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b1, 32'hFFFF_FFFF, 1'b0},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_VENDOR_ID, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b1, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_DEV_FEAT, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b1, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_DEV_FEAT_SEL, vmmio_pkg::ACCESS_WORD, 32'h1,
				1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_DEV_FEAT, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b1, 32'hFFFF_FFFF, 1'b0},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_DEV_FEAT_SEL, vmmio_pkg::ACCESS_WORD,
				32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_DEV_FEAT, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b1, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_QUEUE_MAX, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b1, 32'(vmmio_pkg::QUEUE_MAX_LEN), 1'b0},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_MAGIC, 4'hF, 32'h0,
				1'b1, 32'h0, 1'b1},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_MAGIC, vmmio_pkg::ACCESS_WORD, 32'hFFFF_FFFF,
				1'b1, 32'h0, 1'b1},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_QUEUE_NOTIFY, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b1, 32'h0, 1'b1},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_DRV_FEAT_SEL, vmmio_pkg::ACCESS_WORD,
				32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_DRV_FEAT, vmmio_pkg::ACCESS_WORD,
				32'hDEAD_BEEF, 1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_DRV_FEAT, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_QUEUE_SEL, vmmio_pkg::ACCESS_WORD, 32'(NQ),
				1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_QUEUE_MAX, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b1, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_QUEUE_SEL, vmmio_pkg::ACCESS_WORD,
				32'(NQ - 1), 1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_USED_HI, vmmio_pkg::ACCESS_WORD,
				32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_READ, vmmio_pkg::OFF_USED_HI, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_QUEUE_NOTIFY, vmmio_pkg::ACCESS_WORD,
				32'(NQ), 1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_QUEUE_NOTIFY, vmmio_pkg::ACCESS_WORD,
				32'(NQ - 1), 1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_USED, vmmio_pkg::OFF_MAGIC, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b0, 32'h0, 1'b0},
			'{KIND_UNUSED, 8'hFF, 4'hF, 32'hFFFF_FFFF,
				1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_STATUS, vmmio_pkg::ACCESS_WORD, 32'h0,
				1'b0, 32'h0, 1'b0},
			'{vmmio_pkg::KIND_WRITE, vmmio_pkg::OFF_STATUS, 4'h0, 32'hFF,
				1'b1, 32'h0, 1'b1}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_identity(32'hFFFF_FFFF, 32'h0, 64'hFFFF_FFFF_0000_0000);
		for (int i = 0; i < PLAN_LEN; i++) begin
			send_request(bringup_plan[i].k, bringup_plan[i].off, bringup_plan[i].sz,
				bringup_plan[i].d, bringup_plan[i].known, bringup_plan[i].rd, bringup_plan[i].err);
			sender_gap();
		end
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			feat_pick = {$urandom, $urandom};
			case (ph)
				0:       set_identity(32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
				1:       set_identity(32'h0, 32'h0, '0);
				default: set_identity($urandom, $urandom, feat_pick);
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				calm = (ph == 3) && (i >= PHASE_ITEMS - CALM_ITEMS);
				r = $urandom_range(99);
				k = (r < 3) ? KIND_UNUSED : (r < 13) ? vmmio_pkg::KIND_USED :
					(r < 55) ? vmmio_pkg::KIND_READ : vmmio_pkg::KIND_WRITE;
				off = ($urandom_range(99) < 92) ? reg_map[$urandom_range(22)] : 8'($urandom);
				sz = ($urandom_range(99) < 92) ? vmmio_pkg::ACCESS_WORD : 4'($urandom);
				d = $urandom;
				case (off)
					vmmio_pkg::OFF_QUEUE_SEL, vmmio_pkg::OFF_QUEUE_NOTIFY:
						if ($urandom_range(99) < 85) d = $urandom_range(NQ + 1);
					vmmio_pkg::OFF_DEV_FEAT_SEL:
						if ($urandom_range(99) < 70) d = $urandom_range(2);
					vmmio_pkg::OFF_STATUS: begin
						if ($urandom_range(99) < 8)
							d[7:0] = 8'h0;
						else if (d[7:0] == 8'h0)
							d[0] = 1'b1;
					end
					default: ;
				endcase
				send_request(k, off, sz, d, 1'b0, 32'h0, 1'b0);
				sender_gap();
			end
			drain();
		end

		$display("Checked %0d results from %0d requests under %0d identity settings.",
			n_results, n_accepted, n_settings);
		$display("Seen: %0d queue notifies, %0d transport resets, %0d access errors.",
			n_notify, n_resets, n_errors);
		if (n_fail == 0)
			$display("** virtio_mmio_transport_registers_top: PASSED **");
		else
			$display("** virtio_mmio_transport_registers_top: FAILED **");
		$finish;
	end

endmodule
